>>> design/adc_pkg.sv
// Shared widths, register map and types for the anisotropic distance check.
package adc_pkg;

	localparam int COORD_W     = 16;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int ROT_W       = 16;
	localparam int PROD_W      = DIFF_W + ROT_W;
	localparam int ROT_SUM_W   = PROD_W + 1;
	localparam int SCALE_W     = 16;
	localparam int SCALED_W    = ROT_SUM_W + SCALE_W + 1;
	localparam int FRAC_DROP   = 18;
	localparam int COMP_W      = 25;
	localparam int SQ_W        = 2 * (COMP_W - 2) + 1;
	localparam int SUM_W       = SQ_W + 1;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int DIST_W      = 24;
	localparam int RADIUS_W    = 24;

	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_W   = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RADIUS      = 3'd0,
		REG_ROT_00      = 3'd1,
		REG_ROT_01      = 3'd2,
		REG_ROT_10      = 3'd3,
		REG_ROT_11      = 3'd4,
		REG_INV_SCALE_X = 3'd5,
		REG_INV_SCALE_Y = 3'd6
	} reg_idx_t;

	localparam logic [RADIUS_W-1:0]     RADIUS_RST = '1;
	localparam logic signed [ROT_W-1:0] ROT_ONE    = 16'sd16384;
	localparam logic [SCALE_W-1:0]      SCALE_ONE  = 16'd4096;

endpackage

>>> design/adc_in_if.sv
// Point-pair input channel.
interface adc_in_if;
	logic valid;
	logic ready;
	logic signed [adc_pkg::COORD_W-1:0] first_x;
	logic signed [adc_pkg::COORD_W-1:0] first_y;
	logic signed [adc_pkg::COORD_W-1:0] second_x;
	logic signed [adc_pkg::COORD_W-1:0] second_y;

	modport source (output valid, output first_x, output first_y,
		output second_x, output second_y, input ready);
	modport sink (input valid, input first_x, input first_y,
		input second_x, input second_y, output ready);
endinterface

>>> design/adc_out_if.sv
// Distance result channel.
interface adc_out_if;
	logic valid;
	logic ready;
	logic [adc_pkg::DIST_W-1:0] distance;
	logic within_res;

	modport source (output valid, output distance, output within_res, input ready);
	modport sink (input valid, input distance, input within_res, output ready);
endinterface

>>> design/adc_isqrt.sv
// Pipelined square root, one root bit per stage, returns root and remainder.
module adc_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         sum_vld,
	input  logic [adc_pkg::SUM_W-1:0]    sum,
	output logic                         root_vld,
	output logic [adc_pkg::ROOT_W-1:0]   root,
	output logic [adc_pkg::SUM_W-1:0]    rem
);

	localparam int TRIAL_W = adc_pkg::SUM_W + 1;

	logic [adc_pkg::SUM_W-1:0]  rem_s  [adc_pkg::ROOT_W];
	logic [adc_pkg::ROOT_W-1:0] root_s [adc_pkg::ROOT_W];
	logic                       vld_s  [adc_pkg::ROOT_W];

	for (genvar j = 0; j < adc_pkg::ROOT_W; j++) begin : g_step
		localparam int K = adc_pkg::ROOT_W - 1 - j;

		logic [adc_pkg::SUM_W-1:0]  rem_in;
		logic [adc_pkg::ROOT_W-1:0] root_in;
		logic                       vld_in;
		logic [TRIAL_W-1:0]         trial;
		logic                       take;

		if (j == 0) begin : g_first
			assign rem_in  = sum;
			assign root_in = '0;
			assign vld_in  = sum_vld;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign vld_in  = vld_s[j-1];
		end

		// (Q + 2^k)^2 - Q^2 = Q*2^(k+1) + 2^(2k)
		assign trial = (TRIAL_W'(root_in) << (K + 1)) | (TRIAL_W'(1) << (2 * K));
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					rem_s[j]  <= rem_in - trial[adc_pkg::SUM_W-1:0];
					root_s[j] <= root_in | (adc_pkg::ROOT_W'(1) << K);
				end else begin
					rem_s[j]  <= rem_in;
					root_s[j] <= root_in;
				end
			end
		end
	end

	assign root_vld = vld_s[adc_pkg::ROOT_W-1];
	assign root     = root_s[adc_pkg::ROOT_W-1];
	assign rem      = rem_s[adc_pkg::ROOT_W-1];

endmodule

>>> design/anisotropic_distance_check.sv
// Top level: config registers, rotate/scale/square pipeline, rounded root and radius test.
//
//  channel | dir | beat
//  req     | in  | first_x, first_y, second_x, second_y
//  rsp     | out | distance, within_res
//  apb     | in  | register write/read, 7 registers at 4*i
//
// The pipe has 7 arithmetic stages, 24 root stages and one output register.
// One beat per cycle sustained while rsp is ready; the widest work in a stage is a
// 17x16 or 34x17 multiply, a 25x25 square, or one 49-bit compare/subtract of the root.
// Reset clears the stage valid bits and loads identity matrix, unit scales, full radius.
// A stall on rsp freezes the whole pipe; req.ready follows rsp.ready combinationally.
module anisotropic_distance_check (
	input  logic                               clk,
	input  logic                               arst_n,
	adc_in_if.sink                             req,
	adc_out_if.source                          rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [adc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [adc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [adc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam logic signed [adc_pkg::SCALED_W-1:0] ROUND_BIAS =
		adc_pkg::SCALED_W'(1) << (adc_pkg::FRAC_DROP - 1);
	localparam logic signed [adc_pkg::SCALED_W-1:0] COMP_MAX =
		adc_pkg::SCALED_W'(1) << (adc_pkg::COMP_W - 2);
	localparam logic signed [adc_pkg::SCALED_W-1:0] COMP_MIN = -COMP_MAX;

	// registers
	logic [adc_pkg::RADIUS_W-1:0]      radius_q;
	logic signed [adc_pkg::ROT_W-1:0]  rot_00_q, rot_01_q, rot_10_q, rot_11_q;
	logic [adc_pkg::SCALE_W-1:0]       inv_scale_x_q, inv_scale_y_q;
	adc_pkg::reg_idx_t                 reg_idx;
	logic                              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = adc_pkg::reg_idx_t'(paddr[adc_pkg::APB_ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= adc_pkg::RADIUS_RST;
			rot_00_q      <= adc_pkg::ROT_ONE;
			rot_01_q      <= '0;
			rot_10_q      <= '0;
			rot_11_q      <= adc_pkg::ROT_ONE;
			inv_scale_x_q <= adc_pkg::SCALE_ONE;
			inv_scale_y_q <= adc_pkg::SCALE_ONE;
		end else if (wr_en) begin
			unique case (reg_idx)
				adc_pkg::REG_RADIUS:      radius_q      <= pwdata[adc_pkg::RADIUS_W-1:0];
				adc_pkg::REG_ROT_00:      rot_00_q      <= pwdata[adc_pkg::ROT_W-1:0];
				adc_pkg::REG_ROT_01:      rot_01_q      <= pwdata[adc_pkg::ROT_W-1:0];
				adc_pkg::REG_ROT_10:      rot_10_q      <= pwdata[adc_pkg::ROT_W-1:0];
				adc_pkg::REG_ROT_11:      rot_11_q      <= pwdata[adc_pkg::ROT_W-1:0];
				adc_pkg::REG_INV_SCALE_X: inv_scale_x_q <= pwdata[adc_pkg::SCALE_W-1:0];
				adc_pkg::REG_INV_SCALE_Y: inv_scale_y_q <= pwdata[adc_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			adc_pkg::REG_RADIUS:      prdata = adc_pkg::APB_DATA_W'(radius_q);
			adc_pkg::REG_ROT_00:      prdata = adc_pkg::APB_DATA_W'(rot_00_q);
			adc_pkg::REG_ROT_01:      prdata = adc_pkg::APB_DATA_W'(rot_01_q);
			adc_pkg::REG_ROT_10:      prdata = adc_pkg::APB_DATA_W'(rot_10_q);
			adc_pkg::REG_ROT_11:      prdata = adc_pkg::APB_DATA_W'(rot_11_q);
			adc_pkg::REG_INV_SCALE_X: prdata = adc_pkg::APB_DATA_W'(inv_scale_x_q);
			adc_pkg::REG_INV_SCALE_Y: prdata = adc_pkg::APB_DATA_W'(inv_scale_y_q);
			default:                  prdata = '0;
		endcase
	end

	// pipeline
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic out_vld_q;

	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;

	logic signed [adc_pkg::DIFF_W-1:0]    d_x_s1, d_y_s1;
	logic signed [adc_pkg::PROD_W-1:0]    p_00_s2, p_01_s2, p_10_s2, p_11_s2;
	logic signed [adc_pkg::ROT_SUM_W-1:0] a_x_s3, a_y_s3;
	logic signed [adc_pkg::SCALED_W-1:0]  m_x_s4, m_y_s4;
	logic signed [adc_pkg::COMP_W-1:0]    c_x_s5, c_y_s5;
	logic [adc_pkg::SQ_W-1:0]             sq_x_s6, sq_y_s6;
	logic [adc_pkg::SUM_W-1:0]            sum_s7;

	logic signed [adc_pkg::COMP_W-1:0]    c_x, c_y;
	logic signed [2*adc_pkg::COMP_W-1:0]  sq_x_full, sq_y_full;

	function automatic logic signed [adc_pkg::COMP_W-1:0] round_sat(
		input logic signed [adc_pkg::SCALED_W-1:0] m);
		logic signed [adc_pkg::SCALED_W-1:0] biased;
		logic signed [adc_pkg::SCALED_W-1:0] shifted;
		biased  = m + ROUND_BIAS;
		shifted = biased >>> adc_pkg::FRAC_DROP;
		if (shifted > COMP_MAX) begin
			return adc_pkg::COMP_W'(COMP_MAX);
		end else if (shifted < COMP_MIN) begin
			return adc_pkg::COMP_W'(COMP_MIN);
		end
		return adc_pkg::COMP_W'(shifted);
	endfunction

	assign c_x       = round_sat(m_x_s4);
	assign c_y       = round_sat(m_y_s4);
	assign sq_x_full = c_x_s5 * c_x_s5;
	assign sq_y_full = c_y_s5 * c_y_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_x_s1  <= adc_pkg::DIFF_W'(req.first_x) - adc_pkg::DIFF_W'(req.second_x);
			d_y_s1  <= adc_pkg::DIFF_W'(req.first_y) - adc_pkg::DIFF_W'(req.second_y);
			p_00_s2 <= adc_pkg::PROD_W'(d_x_s1) * adc_pkg::PROD_W'(rot_00_q);
			p_01_s2 <= adc_pkg::PROD_W'(d_x_s1) * adc_pkg::PROD_W'(rot_01_q);
			p_10_s2 <= adc_pkg::PROD_W'(d_y_s1) * adc_pkg::PROD_W'(rot_10_q);
			p_11_s2 <= adc_pkg::PROD_W'(d_y_s1) * adc_pkg::PROD_W'(rot_11_q);
			// row vector times matrix; magnitude stays far below the 2^41 clamp
			a_x_s3  <= adc_pkg::ROT_SUM_W'(p_00_s2) + adc_pkg::ROT_SUM_W'(p_10_s2);
			a_y_s3  <= adc_pkg::ROT_SUM_W'(p_01_s2) + adc_pkg::ROT_SUM_W'(p_11_s2);
			m_x_s4  <= adc_pkg::SCALED_W'(a_x_s3)
				* signed'(adc_pkg::SCALED_W'(inv_scale_x_q));
			m_y_s4  <= adc_pkg::SCALED_W'(a_y_s3)
				* signed'(adc_pkg::SCALED_W'(inv_scale_y_q));
			c_x_s5  <= c_x;
			c_y_s5  <= c_y;
			sq_x_s6 <= sq_x_full[adc_pkg::SQ_W-1:0];
			sq_y_s6 <= sq_y_full[adc_pkg::SQ_W-1:0];
			sum_s7  <= adc_pkg::SUM_W'(sq_x_s6) + adc_pkg::SUM_W'(sq_y_s6);
		end
	end

	logic                          root_vld;
	logic [adc_pkg::ROOT_W-1:0]    root;
	logic [adc_pkg::SUM_W-1:0]     rem;
	logic [adc_pkg::DIST_W-1:0]    dist_rnd;

	adc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.sum_vld  (vld_s7),
		.sum      (sum_s7),
		.root_vld (root_vld),
		.root     (root),
		.rem      (rem)
	);

	// round to nearest: bump when remainder exceeds root
	assign dist_rnd = adc_pkg::DIST_W'(root)
		+ adc_pkg::DIST_W'(rem > adc_pkg::SUM_W'(root));

	logic [adc_pkg::DIST_W-1:0] dist_q;
	logic                       within_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= root_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q   <= dist_rnd;
			within_q <= dist_rnd <= radius_q;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.distance   = dist_q;
	assign rsp.within_res = within_q;

endmodule

>>> tb/tb_anisotropic_distance_check.sv
// Testbench for anisotropic_distance_check: point-pair beats checked against a distance predictor.
`timescale 1ns / 100ps

module tb_anisotropic_distance_check;
	import adc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 5'd28;

	typedef struct {
		logic signed [COORD_W-1:0] fx;
		logic signed [COORD_W-1:0] fy;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
	} pair_t;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic in_radius;
	} dist_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	adc_in_if req ();
	adc_out_if rsp ();

	anisotropic_distance_check dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [RADIUS_W-1:0] cfg_radius = RADIUS_RST;
	logic signed [ROT_W-1:0] cfg_rot [4] = '{ROT_ONE, 16'sd0, 16'sd0, ROT_ONE};
	logic [SCALE_W-1:0] cfg_scale_x = SCALE_ONE;
	logic [SCALE_W-1:0] cfg_scale_y = SCALE_ONE;

	pair_t pair_queue [$];
	dist_t dist_due [$];
	int errors = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int quiet = 0;
	logic calm = 1'b0;
	logic drive;
	dist_t want;

	initial forever #6 clk = ~clk;

	function automatic longint scale_sat(longint comp, logic [SCALE_W-1:0] s);
		longint t;
		t = (comp * longint'({1'b0, s}) + (longint'(1) <<< 17)) >>> FRAC_DROP;
		if (t > (longint'(1) <<< 23))
			t = longint'(1) <<< 23;
		if (t < -(longint'(1) <<< 23))
			t = -(longint'(1) <<< 23);
		return t;
	endfunction

	function automatic logic [DIST_W-1:0] round_root(longint unsigned sq);
		longint unsigned rest, root, probe;
		rest = sq;
		root = 0;
		probe = 64'd1 << 48;
		while (probe > rest)
			probe >>= 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		if (sq - root * root > root)
			root++;
		return root[DIST_W-1:0];
	endfunction

	function automatic dist_t aniso_distance(pair_t p);
		longint dx, dy, cx, cy;
		dist_t r;
		dx = longint'(p.fx) - longint'(p.sx);
		dy = longint'(p.fy) - longint'(p.sy);
		cx = scale_sat(dx * longint'(cfg_rot[0]) + dy * longint'(cfg_rot[2]), cfg_scale_x);
		cy = scale_sat(dx * longint'(cfg_rot[1]) + dy * longint'(cfg_rot[3]), cfg_scale_y);
		r.distance = round_root(longint'(cx * cx + cy * cy));
		r.in_radius = (r.distance <= cfg_radius);
		return r;
	endfunction

	// random upper bits; the register keeps only its own width
	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input int value);
		logic [APB_DATA_W-1:0] data;
		data = $urandom();
		if (reg_idx_t'(addr[4:2]) == REG_RADIUS)
			data[RADIUS_W-1:0] = value[RADIUS_W-1:0];
		else if (addr != SPARE_ADDR)
			data[15:0] = value[15:0];
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx_t'(addr[4:2]))
			REG_RADIUS:      cfg_radius = data[RADIUS_W-1:0];
			REG_ROT_00:      cfg_rot[0] = data[ROT_W-1:0];
			REG_ROT_01:      cfg_rot[1] = data[ROT_W-1:0];
			REG_ROT_10:      cfg_rot[2] = data[ROT_W-1:0];
			REG_ROT_11:      cfg_rot[3] = data[ROT_W-1:0];
			REG_INV_SCALE_X: cfg_scale_x = data[SCALE_W-1:0];
			REG_INV_SCALE_Y: cfg_scale_y = data[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input int radius, input int r00, input int r01, input int r10,
			input int r11, input int sx, input int sy);
		reg_write({REG_RADIUS, 2'b00}, radius);
		reg_write({REG_ROT_00, 2'b00}, r00);
		reg_write({REG_ROT_01, 2'b00}, r01);
		reg_write({REG_ROT_10, 2'b00}, r10);
		reg_write({REG_ROT_11, 2'b00}, r11);
		reg_write({REG_INV_SCALE_X, 2'b00}, sx);
		reg_write({REG_INV_SCALE_Y, 2'b00}, sy);
	endtask

	task automatic push_pair(input int fx, input int fy, input int sx, input int sy);
		pair_t p;
		p.fx = fx[COORD_W-1:0];
		p.fy = fy[COORD_W-1:0];
		p.sx = sx[COORD_W-1:0];
		p.sy = sy[COORD_W-1:0];
		pair_queue.push_back(p);
	endtask

	task automatic settle();
		while (pair_queue.size() != 0 || dist_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic int rand_rot();
		case ($urandom_range(0, 7))
			0: return -16384;
			1: return 16384;
			2: return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 32768)) - 16384;
		endcase
	endfunction

	function automatic int rand_scale();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 65535;
			3: return int'($urandom_range(3500, 4700));
			default: return int'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic int rand_radius();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 24'hFFFFFF;
			2: return int'($urandom_range(0, 1 << 18));
			3: return int'($urandom_range(0, 24'hFFFFFF));
			default: return int'($urandom_range(0, 1 << 22));
		endcase
	endfunction

	function automatic int rail_coord();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic push_random(input int n);
		int fx, fy, ox, oy;
		repeat (n) begin
			fx = int'($urandom_range(0, 65535)) - 32768;
			fy = int'($urandom_range(0, 65535)) - 32768;
			ox = int'($urandom_range(0, 600)) - 300;
			oy = int'($urandom_range(0, 600)) - 300;
			case ($urandom_range(0, 7))
				0, 1: push_pair(fx, fy, $urandom(), $urandom());
				2, 3, 4: push_pair(fx, fy, fx + ox, fy + oy);
				5: push_pair(ox * 7, oy * 7, 0, 0);
				6: push_pair(fx, fy, 0, 0);
				default: push_pair(rail_coord(), rail_coord(), rail_coord(), rail_coord());
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.first_x <= '0;
			req.first_y <= '0;
			req.second_x <= '0;
			req.second_y <= '0;
			src_gap = 0;
		end else begin
			if (req.valid && req.ready)
				dist_due.push_back(aniso_distance(pair_queue.pop_front()));
			if (!req.valid || req.ready) begin
				drive = 1'b0;
				if (src_gap > 0)
					src_gap--;
				else if (pair_queue.size() != 0) begin
					if (!calm && $urandom_range(0, 9) == 0)
						src_gap = $urandom_range(0, 11);
					else
						drive = 1'b1;
				end
				req.valid <= drive;
				if (drive) begin
					req.first_x <= pair_queue[0].fx;
					req.first_y <= pair_queue[0].fy;
					req.second_x <= pair_queue[0].sx;
					req.second_y <= pair_queue[0].sy;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (dist_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected beat: distance %0d within_res %0b",
							rsp.distance, rsp.within_res);
				end else begin
					want = dist_due.pop_front();
					if (rsp.distance !== want.distance || rsp.within_res !== want.in_radius) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: distance exp %0d got %0d, within_res exp %0b got %0b",
								want.distance, rsp.distance, want.in_radius, rsp.within_res);
					end
				end
			end
			if (sink_gap > 0)
				sink_gap--;
			else if (!calm && $urandom_range(0, 15) == 0)
				sink_gap = $urandom_range(1, 12);
			rsp.ready <= (sink_gap == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// isotropic reset state: extremes of the coordinates
		push_pair(0, 0, 0, 0);
		push_pair(32767, 32767, -32768, -32768);
		push_pair(-32768, -32768, 32767, 32767);
		push_pair(32767, -32768, -32768, 32767);
		push_pair(3, 4, 0, 0);
		push_pair(-1, -1, 0, 0);
		push_pair(-32768, 0, 0, 0);
		push_pair(0, 32767, 0, -1);
		settle();

		// distance equal to the radius; spare address must not disturb it
		reg_write({REG_RADIUS, 2'b00}, 1280);
		reg_write(SPARE_ADDR, 0);
		push_pair(3, 4, 0, 0);
		push_pair(0, -5, 0, 0);
		push_pair(4, 4, 0, 0);
		push_pair(10, 10, 7, 6);
		push_pair(1, 1, 0, 0);
		settle();

		// zero x scale, matrix past unity, max y scale, zero radius
		set_regs(0, -32768, 32767, -16384, 16384, 0, 65535);
		push_pair(0, 0, 0, 0);
		push_pair(32767, 32767, -32768, -32768);
		push_pair(1, 0, 0, 0);
		push_pair(0, 1, 0, 0);
		push_pair(-32768, -32768, 32767, 32767);
		push_pair(5, -3, 2, 7);
		settle();

		// smallest scales: rounding ties go up
		set_regs(1, 16384, 0, 0, 16384, 1, 1);
		push_pair(8, 0, 0, 0);
		push_pair(-8, 0, 0, 0);
		push_pair(0, -24, 0, 0);
		push_pair(24, 0, 0, 0);
		settle();

		for (int ph = 0; ph < 9; ph++) begin
			set_regs(rand_radius(), rand_rot(), rand_rot(), rand_rot(), rand_rot(),
				rand_scale(), rand_scale());
			if ($urandom_range(0, 2) == 0)
				reg_write(SPARE_ADDR, $urandom());
			if (ph == 8)
				calm = 1'b1;
			push_random(125);
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && dist_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
